[hw/rtl/tt_pkg.sv]
// tokenizer package: result kind codes, character constants, result record type
// and character class helpers; no dependencies
`default_nettype none

package tt_pkg;

   typedef enum logic [2:0] {
      KIND_SYMBOL    = 3'd0,
      KIND_WORD_BYTE = 3'd1,
      KIND_WORD_DONE = 3'd2,
      KIND_STR_BYTE  = 3'd3,
      KIND_STR_DONE  = 3'd4,
      KIND_INTEGER   = 3'd5,
      KIND_END       = 3'd6,
      KIND_ERROR     = 3'd7
   } kind_type;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_QUOTE = 8'h22;

   localparam int VALUE_BITS = 64;
   localparam int FIELD_OFFSET_BITS = 16;

   typedef struct packed {
      kind_type                     kind;
      logic [VALUE_BITS-1:0]        value;
      logic [FIELD_OFFSET_BITS-1:0] offset;
      logic                         last;
   } result_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
   endfunction

endpackage

`default_nettype wire

[hw/rtl/text_tokenizer.sv]
// text_tokenizer: streaming line tokenizer, one byte item in, up to two result items out
// a byte accepted into the input register is classified from it once its results fit, and
// its first result is then registered in the result register, raising tvalid
// throughput: one byte per cycle while rsp_tready; a two-result byte stalls the next byte
// reset: synchronous, active high; clears the tokenizer state and all valid flags
// depends on tt_pkg (kind codes, character constants, result record)
`default_nettype none

module text_tokenizer
   import tt_pkg::*;
#(
   parameter int OFFSET_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input byte stream
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] ch
   // result stream
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [79:0] rsp_tdata,   // [63:0] value, [79:64] offset
   output      logic [2:0]  rsp_tuser,   // [2:0] kind
   output      logic        rsp_tlast    // final result of an input byte
);

   // tokenizer mode
   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_WORD,
      MODE_INT,
      MODE_INT_NEG,
      MODE_MINUS,
      MODE_STR,
      MODE_DRAIN
   } mode_type;

   localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

   // input register
   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_ch_ff, in_ch_in;

   // tokenizer state
   mode_type               mode_ff, mode_in;
   logic [62:0]            acc_ff, acc_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;

   // result register: up to two results of one byte
   result_type             res0_ff, res0_in;
   result_type             res1_ff, res1_in;
   logic [1:0]             cnt_ff, cnt_in;

   logic                   process;
   logic                   pop;
   logic                   accept;

   // classification of the byte in the input register
   logic                   e1_v, e2_v, do_disp;
   result_type             e1, e2;
   logic [1:0]             n_res;
   logic [3:0]             digit;
   logic [66:0]            acc_next;
   logic                   ovf;
   logic [63:0]            mag64;
   logic [63:0]            int_value;
   logic [63:0]            ch_value;
   logic [OFFSET_BITS+15:0] pos_wide, start_wide;
   logic [15:0]            pos_off, start_off;

   // handshakes; the byte is classified only when its results fit
   assign pop        = rsp_tvalid && rsp_tready;
   assign process    = in_valid_ff && ((cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_tready));
   assign req_tready = !in_valid_ff || process;
   assign accept     = req_tvalid && req_tready;

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = {res0_ff.offset, res0_ff.value};
   assign rsp_tuser  = res0_ff.kind;
   assign rsp_tlast  = res0_ff.last;

   // offsets go out masked or zero-extended to the 16-bit field
   assign pos_wide   = {16'b0, pos_ff};
   assign start_wide = {16'b0, start_ff};
   assign pos_off    = pos_wide[15:0];
   assign start_off  = start_wide[15:0];

   // digit value, decimal shift-add and overflow past 2^63-1
   assign digit     = in_ch_ff[3:0];
   assign acc_next  = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + {63'b0, digit};
   assign ovf       = |acc_next[66:63];
   assign mag64     = {1'b0, acc_ff};
   assign int_value = (mode_ff == MODE_INT_NEG) ? (~mag64 + 64'd1) : mag64;
   assign ch_value  = {56'b0, in_ch_ff};

   always_comb begin
      e1       = '0;
      e2       = '0;
      e1_v     = 1'b0;
      e2_v     = 1'b0;
      do_disp  = 1'b0;
      mode_in  = mode_ff;
      acc_in   = acc_ff;
      start_in = start_ff;
      pos_in   = pos_ff;

      // continue or close the pending token
      unique case (mode_ff)
         MODE_WORD: begin
            e1_v      = 1'b1;
            e1.offset = start_off;
            if (is_alpha(in_ch_ff) || is_digit(in_ch_ff)) begin
               e1.kind  = KIND_WORD_BYTE;
               e1.value = ch_value;
            end else begin
               e1.kind = KIND_WORD_DONE;
               do_disp = 1'b1;
            end
         end
         MODE_INT, MODE_INT_NEG: begin
            if (is_digit(in_ch_ff)) begin
               if (ovf) begin
                  e1_v      = 1'b1;
                  e1.kind   = KIND_ERROR;
                  e1.offset = start_off;
                  mode_in   = MODE_DRAIN;
               end else begin
                  acc_in = acc_next[62:0];
               end
            end else begin
               e1_v      = 1'b1;
               e1.kind   = KIND_INTEGER;
               e1.value  = int_value;
               e1.offset = start_off;
               do_disp   = 1'b1;
            end
         end
         MODE_MINUS: begin
            if (is_digit(in_ch_ff)) begin
               mode_in = MODE_INT_NEG;
               acc_in  = {59'b0, digit};
            end else begin
               // lone minus becomes a symbol ahead of this byte's own result
               e1_v      = 1'b1;
               e1.kind   = KIND_SYMBOL;
               e1.value  = {56'b0, CH_MINUS};
               e1.offset = start_off;
               do_disp   = 1'b1;
            end
         end
         MODE_STR: begin
            e1_v      = 1'b1;
            e1.offset = start_off;
            if (in_ch_ff == CH_QUOTE) begin
               e1.kind = KIND_STR_DONE;
               mode_in = MODE_IDLE;
            end else if (in_ch_ff == CH_NUL) begin
               // unterminated string: error and no end item
               e1.kind = KIND_ERROR;
            end else begin
               e1.kind  = KIND_STR_BYTE;
               e1.value = ch_value;
            end
         end
         MODE_DRAIN: begin
            // swallow everything up to the terminator
         end
         MODE_IDLE: begin
            do_disp = 1'b1;
         end
         default: begin
            do_disp = 1'b1;
         end
      endcase

      // start a new token with this byte
      if (do_disp) begin
         mode_in = MODE_IDLE;
         priority if (in_ch_ff == CH_NUL) begin
            e2_v      = 1'b1;
            e2.kind   = KIND_END;
            e2.offset = pos_off;
         end else if (is_space(in_ch_ff)) begin
            // separator, dropped
         end else if (in_ch_ff == CH_QUOTE) begin
            mode_in  = MODE_STR;
            start_in = pos_ff;
         end else if (is_digit(in_ch_ff)) begin
            mode_in  = MODE_INT;
            acc_in   = {59'b0, digit};
            start_in = pos_ff;
         end else if (is_alpha(in_ch_ff)) begin
            mode_in   = MODE_WORD;
            start_in  = pos_ff;
            e2_v      = 1'b1;
            e2.kind   = KIND_WORD_BYTE;
            e2.value  = ch_value;
            e2.offset = pos_off;
         end else if (in_ch_ff == CH_MINUS) begin
            mode_in  = MODE_MINUS;
            start_in = pos_ff;
         end else begin
            e2_v      = 1'b1;
            e2.kind   = KIND_SYMBOL;
            e2.value  = ch_value;
            e2.offset = pos_off;
         end
      end

      // end of line resets the line state, otherwise the position saturates
      if (in_ch_ff == CH_NUL) begin
         mode_in = MODE_IDLE;
         acc_in  = '0;
         pos_in  = '0;
      end else if (pos_ff != POS_MAX) begin
         pos_in = pos_ff + OFFSET_BITS'(1);
      end

      // order results and mark the final one
      n_res   = {1'b0, e1_v} + {1'b0, e2_v};
      res0_in = e1_v ? e1 : e2;
      res1_in = e2;
      res0_in.last = (n_res == 2'd1);
      res1_in.last = 1'b1;
   end

   // input next state
   always_comb begin
      in_ch_in    = accept ? req_tdata : in_ch_ff;
      in_valid_in = accept ? 1'b1 : (process ? 1'b0 : in_valid_ff);
      cnt_in      = cnt_ff;
      if (process) begin
         cnt_in = n_res;
      end else if (pop) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         cnt_ff      <= 2'd0;
         mode_ff     <= MODE_IDLE;
         acc_ff      <= '0;
         start_ff    <= '0;
         pos_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         cnt_ff      <= cnt_in;
         if (process) begin
            mode_ff  <= mode_in;
            acc_ff   <= acc_in;
            start_ff <= start_in;
            pos_ff   <= pos_in;
         end
      end
      // payload registers
      in_ch_ff <= in_ch_in;
      if (process) begin
         res0_ff <= res0_in;
         res1_ff <= res1_in;
      end else if (pop) begin
         res0_ff <= res1_ff;
      end
   end

`ifndef SYNTHESIS
   // a terminator always returns the line position to zero
   a_eol_clears_pos: assert property (@(posedge clock) disable iff (reset)
      process && (in_ch_ff == CH_NUL) |=> (pos_ff == '0))
      else $error("position not cleared after end of line");

   // a draining line produces nothing
   a_drain_silent: assert property (@(posedge clock) disable iff (reset)
      process && (mode_ff == MODE_DRAIN) |-> (n_res == 2'd0))
      else $error("result produced while draining");

   // a stalled byte in the input register is kept unchanged
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !process |=> in_valid_ff && $stable(in_ch_ff))
      else $error("input byte lost while stalled");

   // two pending results block classification
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2) |-> rsp_tvalid && !process)
      else $error("byte classified over pending results");
`endif

endmodule

`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps
// testbench for text_tokenizer: drives byte lines, predicts the token items in-bench
// and checks every result item field by field; depends on tt_pkg and text_tokenizer
module tb;
   import tt_pkg::*;

   localparam int CLOCK_PERIOD = 10;
   localparam int OFFSET_BITS = 16;
   localparam logic [15:0] POSITION_MAX = 16'((1 << OFFSET_BITS) - 1);
   localparam logic [63:0] MAGNITUDE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam int WATCHDOG_CYCLES = 3000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int END_SETTLE_CYCLES = 8;
   localparam int MAX_REPORTS = 100;
   localparam int RANDOM_PHASE_BYTES = 175;

   typedef enum logic [2:0] {
      SCAN_IDLE, SCAN_WORD, SCAN_INT, SCAN_INT_NEG, SCAN_MINUS, SCAN_STRING, SCAN_DRAIN
   } scan_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] ch
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;           // [63:0] value, [79:64] offset
   logic [2:0]  rsp_tuser;           // [2:0] kind
   logic        rsp_tlast;

   text_tokenizer #(.OFFSET_BITS(OFFSET_BITS)) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // idling controls, changed by the test tasks between phases
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int hold_off_requests = 0;
   int hold_off_seen = 0;
   int hold_left = 0;
   int failures = 0;
   int bytes_sent = 0;
   int idle_cycles = 0;

   // tokenizer state as the predictor sees it
   scan_mode_type scan_mode = SCAN_IDLE;
   logic [63:0]   magnitude = '0;
   logic [15:0]   token_start = '0;
   logic [15:0]   position = '0;

   result_type token_results[$];     // results of the byte being predicted
   result_type expected_results[$];  // results still owed by the block

   // ---------------------------------------------------------------- predictor

   function automatic logic char_is_numeral(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic char_is_letter(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic char_is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
   endfunction

   function automatic void add_token(input kind_type k, input logic [63:0] v,
                                     input logic [15:0] off);
      result_type r;
      r.kind = k;
      r.value = v;
      r.offset = off;
      r.last = 1'b0;
      if (token_results.size() < 2)
         token_results.insert(token_results.size(), r);
   endfunction

   // a byte seen with no token open
   function automatic void open_token(input logic [7:0] c, input logic [15:0] pos);
      scan_mode = SCAN_IDLE;
      if (c == CH_NUL) begin
         add_token(KIND_END, 64'd0, pos);
      end else if (char_is_blank(c)) begin
         // separators are dropped
      end else if (c == CH_QUOTE) begin
         scan_mode = SCAN_STRING;
         token_start = pos;
      end else if (char_is_numeral(c)) begin
         scan_mode = SCAN_INT;
         magnitude = 64'(c - "0");
         token_start = pos;
      end else if (char_is_letter(c)) begin
         scan_mode = SCAN_WORD;
         token_start = pos;
         add_token(KIND_WORD_BYTE, 64'(c), pos);
      end else if (c == CH_MINUS) begin
         scan_mode = SCAN_MINUS;
         token_start = pos;
      end else begin
         add_token(KIND_SYMBOL, 64'(c), pos);
      end
   endfunction

   function automatic void predict_byte(input logic [7:0] c);
      logic [15:0] pos;
      logic [63:0] digit;
      logic [63:0] signed_value;
      pos = position;
      token_results.delete();
      case (scan_mode)
         SCAN_WORD: begin
            if (char_is_letter(c) || char_is_numeral(c)) begin
               add_token(KIND_WORD_BYTE, 64'(c), token_start);
            end else begin
               add_token(KIND_WORD_DONE, 64'd0, token_start);
               open_token(c, pos);
            end
         end
         SCAN_INT, SCAN_INT_NEG: begin
            if (char_is_numeral(c)) begin
               digit = 64'(c - "0");
               if (magnitude > (MAGNITUDE_MAX - digit) / 64'd10) begin
                  // overflow: error now, then nothing until the line ends
                  add_token(KIND_ERROR, 64'd0, token_start);
                  scan_mode = SCAN_DRAIN;
               end else begin
                  magnitude = magnitude * 64'd10 + digit;
               end
            end else begin
               signed_value = (scan_mode == SCAN_INT_NEG) ? ~magnitude + 64'd1 : magnitude;
               add_token(KIND_INTEGER, signed_value, token_start);
               open_token(c, pos);
            end
         end
         SCAN_MINUS: begin
            if (char_is_numeral(c)) begin
               scan_mode = SCAN_INT_NEG;
               magnitude = 64'(c - "0");
            end else begin
               // lone minus goes out ahead of this byte's own result
               add_token(KIND_SYMBOL, 64'(CH_MINUS), token_start);
               open_token(c, pos);
            end
         end
         SCAN_STRING: begin
            if (c == CH_QUOTE) begin
               add_token(KIND_STR_DONE, 64'd0, token_start);
               scan_mode = SCAN_IDLE;
            end else if (c == CH_NUL) begin
               add_token(KIND_ERROR, 64'd0, token_start);
            end else begin
               add_token(KIND_STR_BYTE, 64'(c), token_start);
            end
         end
         SCAN_DRAIN: begin
         end
         default: open_token(c, pos);
      endcase
      if (c == CH_NUL) begin
         scan_mode = SCAN_IDLE;
         magnitude = '0;
         position = '0;
      end else if (position < POSITION_MAX) begin
         position = position + 16'd1;
      end
      if (token_results.size() > 0)
         token_results[token_results.size() - 1].last = 1'b1;
      foreach (token_results[i])
         expected_results.insert(expected_results.size(), token_results[i]);
   endfunction

   // ---------------------------------------------------------------- result side

   always @(posedge clock) begin : drive_rsp_ready
      if (hold_off_seen != hold_off_requests) begin
         hold_off_seen = hold_off_requests;
         hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   task automatic report_mismatch(input string field, input longint want, input longint got);
      if (failures < MAX_REPORTS)
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      failures++;
   endtask

   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            if (failures < MAX_REPORTS)
               $error("unexpected result item: kind %0d, value %0d, offset %0d",
                      rsp_tuser, $signed(rsp_tdata[63:0]), rsp_tdata[79:64]);
            failures++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_tuser !== want.kind)
               report_mismatch("kind", longint'(want.kind), longint'(rsp_tuser));
            if (rsp_tdata[63:0] !== want.value)
               report_mismatch("value", longint'(want.value), longint'(rsp_tdata[63:0]));
            if (rsp_tdata[79:64] !== want.offset)
               report_mismatch("offset", longint'(want.offset), longint'(rsp_tdata[79:64]));
            if (rsp_tlast !== want.last)
               report_mismatch("last", longint'(want.last), longint'(rsp_tlast));
         end
      end
   end

   // ends the run when neither side moves an item for too long
   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles = 0;
      else
         idle_cycles = idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // ---------------------------------------------------------------- input side

   task automatic send_byte(input logic [7:0] c);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= c;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predict_byte(c);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i]);
   endtask

   // sender stays quiet until every owed result has come back
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic [7:0] random_letter();
      logic [7:0] l;
      l = 8'($urandom_range(0, 25));
      return $urandom_range(0, 1) ? 8'("a" + l) : 8'("A" + l);
   endfunction

   function automatic logic [7:0] random_string_byte();
      logic [7:0] b;
      b = 8'($urandom_range(1, 255));
      return (b == CH_QUOTE) ? CH_SPACE : b;
   endfunction

   function automatic logic [7:0] random_blank();
      case ($urandom_range(0, 3))
         0: return CH_SPACE;
         1: return CH_TAB;
         2: return CH_LF;
         default: return CH_CR;
      endcase
   endfunction

   // decimal magnitude text, weighted toward small values and the overflow edge
   function automatic string integer_text();
      logic [63:0] mag;
      string s;
      case ($urandom_range(0, 4))
         0: mag = 64'($urandom_range(0, 999));
         1: mag = {$urandom, $urandom} >> $urandom_range(1, 63);
         2: mag = MAGNITUDE_MAX - 64'($urandom_range(0, 2));
         3: mag = MAGNITUDE_MAX + 64'($urandom_range(1, 3));
         default: mag = {$urandom, $urandom} | 64'h8000_0000_0000_0000;
      endcase
      s = $sformatf("%0d", mag);
      if ($urandom_range(0, 9) == 0)
         s = {"00", s};
      return s;
   endfunction

   task automatic send_random_token();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
         send_byte(random_letter());
         repeat ($urandom_range(0, 7))
            send_byte($urandom_range(0, 2) ? random_letter() : 8'("0" + $urandom_range(0, 9)));
      end else if (pick < 40) begin
         send_text(integer_text());
      end else if (pick < 52) begin
         send_byte(CH_MINUS);
         send_text(integer_text());
      end else if (pick < 66) begin
         send_byte(CH_QUOTE);
         repeat ($urandom_range(0, 6))
            send_byte(random_string_byte());
         send_byte(CH_QUOTE);
      end else if (pick < 76) begin
         send_byte(8'($urandom_range(1, 255)));
      end else if (pick < 84) begin
         send_byte(CH_MINUS);
      end else begin
         // raw noise, line ends included
         repeat ($urandom_range(1, 6))
            send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic send_random_line();
      repeat ($urandom_range(1, 6)) begin
         send_random_token();
         if ($urandom_range(0, 3) != 0)
            send_byte(random_blank());
      end
      // now and then leave a string open at the line end
      if ($urandom_range(0, 11) == 0) begin
         send_byte(CH_QUOTE);
         repeat ($urandom_range(0, 3))
            send_byte(random_string_byte());
      end
      send_byte(CH_NUL);
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_token_kinds();
      send_text("Zz09 42\t\"a b\"\"\"#");
      send_byte(8'hFF);
      send_byte(8'h80);
      send_byte(8'h01);
      send_byte(CH_CR);
      send_byte(CH_LF);
      send_byte(CH_NUL);
      wait_for_results();
   endtask

   task automatic test_minus_cases();
      send_text("-5 -a--7 -\"x\"-");
      send_byte(CH_NUL);
      wait_for_results();
   endtask

   task automatic test_line_errors();
      // unterminated string, negative overflow with drain, largest integer
      send_text("\"ab");
      send_byte(CH_NUL);
      send_text("-9223372036854775808 q");
      send_byte(CH_NUL);
      send_text("9223372036854775807");
      send_byte(CH_NUL);
      wait_for_results();
   endtask

   task automatic test_backpressure();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      hold_off_requests++;
      repeat (6)
         send_text("abcdefgh ");
      send_byte(CH_NUL);
      wait_for_results();
   endtask

   task automatic test_random_lines(input int idle_pct, input int stall_pct);
      int stop_at;
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      stop_at = bytes_sent + RANDOM_PHASE_BYTES;
      while (bytes_sent < stop_at)
         send_random_line();
      wait_for_results();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_token_kinds();
      test_minus_cases();
      test_line_errors();
      test_backpressure();
      test_random_lines(0, 0);
      test_random_lines(45, 0);
      test_random_lines(0, 45);
      test_random_lines(8, 8);
      repeat (END_SETTLE_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
